FILE: rtl/spth_pkg.sv
// ============================================================================
// spth_pkg: shared types and constants of the spin-to-heading controller
// Holds the channel payload structs, the item class codes, the register map
// and the configuration bundle passed from the register file to the back end.
// ============================================================================
package spth_pkg;

    // Default number of plan entries.
    localparam int PLAN_DEPTH = 256;

    // Entries in the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Register file geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_GAIN     = 2'd0;
    localparam logic [1:0] REG_INT_TOL  = 2'd1;
    localparam logic [1:0] REG_MAX_RATE = 2'd2;
    localparam logic [1:0] REG_GOAL_TOL = 2'd3;

    // Register reset values.
    localparam logic signed [15:0] GAIN_RESET     = 16'sd4096;
    localparam logic [14:0]        INT_TOL_RESET  = 15'd1252;
    localparam logic [14:0]        MAX_RATE_RESET = 15'd10430;
    localparam logic [14:0]        GOAL_TOL_RESET = 15'd0;

    // Item classes, decided by the front end.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_CTRL    = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic              func;
        logic signed [15:0] heading;
        logic              first_entry;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic signed [15:0] turn_rate;
        logic              goal_reached;
        logic [7:0]        target_index;
        logic              no_plan;
    } out_t;

    // Classified item held in the queue.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] heading;
    } item_t;

    // Configuration bundle.
    typedef struct packed {
        logic signed [15:0] gain;
        logic [14:0]        int_tol;
        logic [14:0]        max_rate;
        logic [14:0]        goal_tol;
    } cfg_t;

    // Address width for a memory of the given depth, at least one bit.
    function automatic int addr_width(input int depth);
        int w;
        begin
            w = $clog2(depth);
            addr_width = (w < 1) ? 1 : w;
        end
    endfunction

endpackage

FILE: rtl/spth_ram.sv
// ============================================================================
// spth_ram: generic single-port-write, single-port-read RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module spth_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/spth_front.sv
// ============================================================================
// spth_front: input acceptance, classification and item queue
// Accepts input transactions, sorts each into load, restart or control and
// holds it in a short queue until the back end takes it.
// ============================================================================
module spth_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spth_pkg::in_t       s_data,
    output logic                item_valid,
    output spth_pkg::item_t     item,
    input  logic                item_pop
);

    localparam int QD = spth_pkg::QUEUE_DEPTH;
    localparam int PW = spth_pkg::addr_width(QD);
    localparam int CW = $clog2(QD + 1);

    spth_pkg::item_t q_mem [QD];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    spth_pkg::item_t in_item;
    logic            push;

    // Classify the incoming transaction.
    always_comb begin
        in_item.heading = s_data.heading;
        if (s_data.func) begin
            in_item.op = spth_pkg::OP_CTRL;
        end else if (s_data.first_entry) begin
            in_item.op = spth_pkg::OP_RESTART;
        end else begin
            in_item.op = spth_pkg::OP_LOAD;
        end
    end

    assign s_ready    = (count_reg != CW'(QD));
    assign push       = s_valid && s_ready;
    assign item_valid = (count_reg != '0);
    assign item       = q_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (item_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !item_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && item_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/spth_regs.sv
// ============================================================================
// spth_regs: configuration register file
// APB-style port holding gain, tolerances and the rate limit.
// ============================================================================
module spth_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spth_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spth_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spth_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output spth_pkg::cfg_t                    cfg
);

    spth_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain     <= spth_pkg::GAIN_RESET;
            cfg_reg.int_tol  <= spth_pkg::INT_TOL_RESET;
            cfg_reg.max_rate <= spth_pkg::MAX_RATE_RESET;
            cfg_reg.goal_tol <= spth_pkg::GOAL_TOL_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                spth_pkg::REG_GAIN:     cfg_reg.gain     <= pwdata[15:0];
                spth_pkg::REG_INT_TOL:  cfg_reg.int_tol  <= pwdata[14:0];
                spth_pkg::REG_MAX_RATE: cfg_reg.max_rate <= pwdata[14:0];
                spth_pkg::REG_GOAL_TOL: cfg_reg.goal_tol <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Register read-back; the gain is returned sign-extended.
    always_comb begin
        unique case (reg_idx)
            spth_pkg::REG_GAIN:     prdata = 32'(cfg_reg.gain);
            spth_pkg::REG_INT_TOL:  prdata = {17'd0, cfg_reg.int_tol};
            spth_pkg::REG_MAX_RATE: prdata = {17'd0, cfg_reg.max_rate};
            spth_pkg::REG_GOAL_TOL: prdata = {17'd0, cfg_reg.goal_tol};
            default:                prdata = '0;
        endcase
    end

endmodule

FILE: rtl/spth_back.sv
// ============================================================================
// spth_back: plan store and heading control sequencer
// Executes queued items: loads write the plan memory, control steps walk the
// plan past passed targets, apply the gain, clamp the rate and post a result.
// ============================================================================
module spth_back #(
    parameter int PLAN_DEPTH = spth_pkg::PLAN_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  spth_pkg::item_t     item,
    output logic                item_pop,
    input  spth_pkg::cfg_t      cfg,
    output logic                m_valid,
    input  logic                m_ready,
    output spth_pkg::out_t      m_data
);

    localparam int AW    = spth_pkg::addr_width(PLAN_DEPTH);
    localparam int LEN_W = $clog2(PLAN_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [15:0]             hdg_reg, hdg_next;
    logic signed [15:0]      err_reg, err_next;
    logic signed [31:0]      prod_reg;
    logic                    empty_reg, empty_next;
    logic                    m_valid_reg;
    spth_pkg::out_t          m_data_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [15:0]             ram_rdata;
    logic [AW-1:0]           ram_raddr;

    logic [LEN_W-1:0]        idx_plus1;
    logic signed [15:0]      err_now;
    logic                    skip;
    logic                    out_free;
    logic                    out_load;
    logic [31:0]             prod_abs;
    logic [19:0]             rate_q;
    logic [14:0]             rate_mag;
    logic                    goal;
    spth_pkg::out_t          result;

    // Magnitude of a 16-bit signed value, 17 bits wide.
    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic [16:0] ext;
        begin
            ext   = {v[15], v};
            mag17 = v[15] ? (17'd0 - ext) : ext;
        end
    endfunction

    spth_ram #(
        .WIDTH  (16),
        .DEPTH  (PLAN_DEPTH),
        .ADDR_W (AW)
    ) u_plan_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (item.heading),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Plan walk terms: wrapped error against the entry just read.
    assign idx_plus1 = LEN_W'(idx_reg) + 1'b1;
    assign err_now   = ram_rdata - hdg_reg;
    assign skip      = (idx_plus1 < len_reg)
                       && (mag17(err_now) < {2'b00, cfg.int_tol});
    assign ram_raddr = (state_reg == ST_CMP && skip) ? AW'(idx_plus1) : idx_reg;

    // Result formation: scale by 1/4096 toward zero, clamp, goal override.
    assign prod_abs = prod_reg[31] ? (32'd0 - prod_reg) : prod_reg;
    assign rate_q   = prod_abs[31:12];
    assign rate_mag = (rate_q > {5'd0, cfg.max_rate}) ? cfg.max_rate : rate_q[14:0];
    assign goal     = (idx_plus1 >= len_reg)
                      && (mag17(err_reg) < {2'b00, cfg.goal_tol});

    always_comb begin
        result.target_index = 8'(idx_reg);
        if (empty_reg) begin
            result.turn_rate    = '0;
            result.goal_reached = 1'b0;
            result.no_plan      = 1'b1;
        end else begin
            result.no_plan      = 1'b0;
            result.goal_reached = goal;
            if (goal) begin
                result.turn_rate = '0;
            end else if (prod_reg[31]) begin
                result.turn_rate = 16'sd0 - $signed({1'b0, rate_mag});
            end else begin
                result.turn_rate = $signed({1'b0, rate_mag});
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        hdg_next   = hdg_reg;
        err_next   = err_reg;
        empty_next = empty_reg;
        item_pop   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = AW'(len_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_pop = 1'b1;
                    hdg_next = item.heading;
                    case (item.op)
                        spth_pkg::OP_RESTART: begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            len_next  = LEN_W'(1);
                            idx_next  = '0;
                        end
                        spth_pkg::OP_CTRL: begin
                            if (len_reg == '0) begin
                                empty_next = 1'b1;
                                state_next = ST_OUT;
                            end else begin
                                empty_next = 1'b0;
                                if (LEN_W'(idx_reg) >= len_reg) begin
                                    idx_next = AW'(len_reg - 1'b1);
                                end
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            if (len_reg < LEN_W'(PLAN_DEPTH)) begin
                                ram_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (skip) begin
                    idx_next = AW'(idx_plus1);
                end else begin
                    err_next   = err_now;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        hdg_reg   <= hdg_next;
        err_reg   <= err_next;
        empty_reg <= empty_next;
        if (state_reg == ST_MUL) begin
            prod_reg <= err_reg * cfg.gain;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/spin_to_heading_controller_unit.sv
// Flow: a load waits in the queue, then is written to the plan memory. A control
// transaction reads the plan memory (its read port once per target walked),
// compares, multiplies by the gain and posts; with an empty plan it posts without reading.
// Rate: one load per cycle while the back end is idle, none during a control step.
// Reset: synchronous, active low; clears the plan length, the index, the queue and
// the output and loads the register defaults. The plan memory is not cleared.
// ============================================================================
// spin_to_heading_controller_unit: heading-plan spin controller, top level
// Front end and queue, plan store and control sequencer, register file.
// ============================================================================
module spin_to_heading_controller_unit #(
    parameter int PLAN_DEPTH = spth_pkg::PLAN_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  spth_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output spth_pkg::out_t                    m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spth_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spth_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spth_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic            item_valid;
    logic            item_pop;
    spth_pkg::item_t item;
    spth_pkg::cfg_t  cfg;

    spth_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    spth_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spth_back #(
        .PLAN_DEPTH (PLAN_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .cfg        (cfg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
